// ----- src/grcd_pkg.sv -----
package grcd_pkg;

    // Default sizes of the block.
    localparam int MAP_DIM_DEF   = 64;
    localparam int SCREEN_W_DEF  = 1024;
    localparam int MAX_STEPS_DEF = 128;

    // Configuration register indexes.
    localparam int          CFG_IDX_W = 3;
    localparam logic [2:0]  CFG_POS_X   = 3'd0;
    localparam logic [2:0]  CFG_POS_Y   = 3'd1;
    localparam logic [2:0]  CFG_DIR_X   = 3'd2;
    localparam logic [2:0]  CFG_DIR_Y   = 3'd3;
    localparam logic [2:0]  CFG_PLANE_X = 3'd4;
    localparam logic [2:0]  CFG_PLANE_Y = 3'd5;
    localparam int          CFG_W       = 16;

    localparam logic [15:0] RST_POS_X   = 16'd0;
    localparam logic [15:0] RST_POS_Y   = 16'd0;
    localparam logic [15:0] RST_DIR_X   = 16'd16384;
    localparam logic [15:0] RST_DIR_Y   = 16'd0;
    localparam logic [15:0] RST_PLANE_X = 16'd0;
    localparam logic [15:0] RST_PLANE_Y = 16'd10813;

    // Opcodes, cell codes and hit sides.
    localparam logic       OP_WRITE     = 1'b0;
    localparam logic       OP_CAST      = 1'b1;
    localparam logic [7:0] CODE_EMPTY   = 8'd0;
    localparam logic [7:0] CODE_SPECIAL = 8'd3;
    localparam logic [1:0] SIDE_X       = 2'd0;
    localparam logic [1:0] SIDE_Y       = 2'd1;
    localparam logic [1:0] SIDE_SPECIAL = 2'd2;

    // Field widths.
    localparam int COORD_W = 6;
    localparam int CODE_W  = 8;
    localparam int COL_W   = 10;
    localparam int DIST_W  = 20;
    localparam int SIDE_W  = 2;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Datapath widths, sized for the largest parameter values.
    localparam int CAM_W  = 22;
    localparam int PROD_W = CFG_W + CAM_W;
    localparam int RAY_W  = 24;
    localparam int MAG_W  = RAY_W - 1;
    localparam int OFF_W  = 20;
    localparam int P_W    = OFF_W + MAG_W;
    localparam int DVD_W  = 34;
    localparam int DVS_W  = MAG_W;

    localparam logic [CAM_W-1:0] ONE_Q14 = CAM_W'(16384);
    localparam logic [10:0]      ONE_Q10 = 11'd1024;

    typedef struct packed {
        logic wr_cell;
        logic ld_col;
        logic ld_cam;
        logic mul;
        logic ray;
        logic init;
        logic step;
        logic check;
        logic dist_start;
        logic ld_dist;
        logic set_nohit;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic init_miss;
        logic step_out;
        logic cell_hit;
    } t_sts;

endpackage

// ----- src/grcd_ram.sv -----
module grcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/grcd_div.sv -----
module grcd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grcd_pkg::DVD_W-1:0]  i_dividend,
    input  logic [grcd_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [grcd_pkg::DVD_W-1:0]  o_quot
);

    localparam int NW = grcd_pkg::DVD_W;
    localparam int SW = grcd_pkg::DVS_W;
    localparam int CW = $clog2(NW + 1);

    logic [SW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [SW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [SW:0] rem_sh;
    logic [SW:0] trial;
    logic        fits;

    // One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign trial  = rem_sh - {1'b0, r_div};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[SW-1:0] : rem_sh[SW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- src/grcd_ctrl.sv -----
module grcd_ctrl #(
    parameter int MAX_STEPS = grcd_pkg::MAX_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  logic           i_s_op,
    output logic           o_s_ready,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output grcd_pkg::t_cmd o_cmd,
    input  grcd_pkg::t_sts i_sts
);

    localparam int NW = $clog2(MAX_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAM,
        S_MUL,
        S_RAY,
        S_INIT,
        S_STEP,
        S_CHECK,
        S_DIST_GO,
        S_DIST_WAIT,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          r_m_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    if (i_s_op == grcd_pkg::OP_CAST) begin
                        o_cmd.ld_col = 1'b1;
                        n_state      = S_CAM;
                    end else begin
                        o_cmd.wr_cell = 1'b1;
                    end
                end
            end
            S_CAM: begin
                o_cmd.ld_cam = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RAY;
            end
            S_RAY: begin
                o_cmd.ray = 1'b1;
                n_state   = S_INIT;
            end
            S_INIT: begin
                n_cnt = '0;
                if (i_sts.init_miss) begin
                    o_cmd.set_nohit = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (i_sts.step_out) begin
                    o_cmd.set_nohit = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.cell_hit) begin
                    n_state = S_DIST_GO;
                end else if (r_cnt == NW'(MAX_STEPS)) begin
                    o_cmd.set_nohit = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIST_GO: begin
                o_cmd.dist_start = 1'b1;
                n_state          = S_DIST_WAIT;
            end
            S_DIST_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_dist = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                // The result moves to the output register once the slot is free.
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.push) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

// ----- src/grcd_dp.sv -----
module grcd_dp #(
    parameter int MAP_DIM  = grcd_pkg::MAP_DIM_DEF,
    parameter int SCREEN_W = grcd_pkg::SCREEN_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [grcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [grcd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [grcd_pkg::COORD_W-1:0]     i_cell_x,
    input  logic [grcd_pkg::COORD_W-1:0]     i_cell_y,
    input  logic [grcd_pkg::CODE_W-1:0]      i_cell_code,
    input  logic [grcd_pkg::COL_W-1:0]       i_column,
    input  grcd_pkg::t_cmd                   i_cmd,
    output grcd_pkg::t_sts                   o_sts,
    output logic [grcd_pkg::DIST_W-1:0]      o_distance,
    output logic [grcd_pkg::SIDE_W-1:0]      o_hit_side,
    output logic [grcd_pkg::COORD_W-1:0]     o_hit_x,
    output logic [grcd_pkg::COORD_W-1:0]     o_hit_y,
    output logic                             o_no_hit
);

    localparam int MW    = $clog2(MAP_DIM) + 2;
    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAW   = grcd_pkg::CAM_W;
    localparam int PW    = grcd_pkg::PROD_W;
    localparam int RW    = grcd_pkg::RAY_W;
    localparam int GW    = grcd_pkg::MAG_W;
    localparam int OW    = grcd_pkg::OFF_W;
    localparam int QW    = grcd_pkg::P_W;
    localparam int NW    = grcd_pkg::DVD_W;
    localparam int DW    = grcd_pkg::DIST_W;
    localparam int CW    = grcd_pkg::COORD_W;

    // The camera quotient 2*column*16384/SCREEN_W comes from a reciprocal multiply.
    // With a 22-bit shift it is exact for every 10-bit column and screens up to 4096.
    localparam int          CAM_SH  = 22;
    localparam logic [31:0] CAM_MUL = 32'(((64'd1 << (CAM_SH + 15)) + 64'(SCREEN_W) - 64'd1)
                                          / 64'(SCREEN_W));

    // Configuration registers.
    logic [15:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= grcd_pkg::RST_POS_X;
            r_pos_y   <= grcd_pkg::RST_POS_Y;
            r_dir_x   <= grcd_pkg::RST_DIR_X;
            r_dir_y   <= grcd_pkg::RST_DIR_Y;
            r_plane_x <= grcd_pkg::RST_PLANE_X;
            r_plane_y <= grcd_pkg::RST_PLANE_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grcd_pkg::CFG_POS_X:   r_pos_x   <= i_cfg_data;
                grcd_pkg::CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                grcd_pkg::CFG_DIR_X:   r_dir_x   <= i_cfg_data;
                grcd_pkg::CFG_DIR_Y:   r_dir_y   <= i_cfg_data;
                grcd_pkg::CFG_PLANE_X: r_plane_x <= i_cfg_data;
                grcd_pkg::CFG_PLANE_Y: r_plane_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Map store.
    logic          wr_ok;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    rdata;

    assign wr_ok = i_cmd.wr_cell && (32'(i_cell_x) < MAP_DIM) && (32'(i_cell_y) < MAP_DIM);
    assign waddr = AW'(32'(i_cell_x) * MAP_DIM + 32'(i_cell_y));

    grcd_ram #(.WIDTH(grcd_pkg::CODE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (waddr),
        .i_wdata (i_cell_code),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Divider for the wall distance.
    logic [NW-1:0]            div_dvd, quot;
    logic [grcd_pkg::DVS_W-1:0] div_dvs;
    logic                     div_done;

    logic [grcd_pkg::COL_W-1:0] r_column;
    logic signed [CAW-1:0]      r_cam;
    logic signed [PW-1:0]       r_prod_x, r_prod_y;
    logic [GW-1:0]              r_arx, r_ary;
    logic                       r_negx, r_negy;
    logic [OW-1:0]              r_offx, r_offy, r_last;
    logic [QW-1:0]              r_px, r_py;
    logic signed [MW-1:0]       r_mx, r_my;
    logic                       r_side;
    logic                       r_special;

    assign div_dvd = NW'({r_last, 14'd0});
    assign div_dvs = r_side ? r_ary : r_arx;

    grcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.dist_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Camera coordinate.
    logic [CAM_SH+19:0] cam_prod;
    logic [19:0]        cam_quo;

    assign cam_prod = (CAM_SH + 20)'(r_column) * (CAM_SH + 20)'(CAM_MUL);
    assign cam_quo  = cam_prod[CAM_SH+19:CAM_SH];

    // Ray setup.
    logic signed [PW-1:0] n_prod_x, n_prod_y;
    logic signed [RW-1:0] n_rx, n_ry;

    assign n_prod_x = r_plane_x * r_cam;
    assign n_prod_y = r_plane_y * r_cam;
    // The arithmetic right shift by 14 is the floor of the Q.14 product.
    assign n_rx = {{(RW-16){r_dir_x[15]}}, r_dir_x} + r_prod_x[PW-1:14];
    assign n_ry = {{(RW-16){r_dir_y[15]}}, r_dir_y} + r_prod_y[PW-1:14];

    // Walk start.
    logic [10:0]   frac_x, frac_y, ioff_x, ioff_y;
    logic [33:0]   ip_x, ip_y;

    assign frac_x = {1'b0, r_pos_x[9:0]};
    assign frac_y = {1'b0, r_pos_y[9:0]};
    assign ioff_x = r_negx ? frac_x : grcd_pkg::ONE_Q10 - frac_x;
    assign ioff_y = r_negy ? frac_y : grcd_pkg::ONE_Q10 - frac_y;
    assign ip_x   = ioff_x * r_ary;
    assign ip_y   = ioff_y * r_arx;

    // One crossing: the side distances compare as offx*|ry| against offy*|rx|.
    logic                 x_first;
    logic signed [MW-1:0] n_mx, n_my;
    logic                 n_in;

    assign x_first = r_px < r_py;
    assign n_mx    = x_first ? (r_negx ? r_mx - 1'b1 : r_mx + 1'b1) : r_mx;
    assign n_my    = x_first ? r_my : (r_negy ? r_my - 1'b1 : r_my + 1'b1);
    assign n_in    = !n_mx[MW-1] && !n_my[MW-1]
                     && (32'(n_mx[MW-2:0]) < MAP_DIM) && (32'(n_my[MW-2:0]) < MAP_DIM);
    assign raddr   = AW'(32'(n_mx[MW-2:0]) * MAP_DIM + 32'(n_my[MW-2:0]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_col) begin
            r_column <= i_column;
        end
        if (i_cmd.ld_cam) begin
            r_cam <= CAW'(cam_quo) - grcd_pkg::ONE_Q14;
        end
        if (i_cmd.mul) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
        end
        if (i_cmd.ray) begin
            r_negx <= n_rx[RW-1];
            r_negy <= n_ry[RW-1];
            r_arx  <= n_rx[RW-1] ? GW'(-n_rx) : GW'(n_rx);
            r_ary  <= n_ry[RW-1] ? GW'(-n_ry) : GW'(n_ry);
        end
        if (i_cmd.init) begin
            r_mx   <= MW'(r_pos_x[15:10]);
            r_my   <= MW'(r_pos_y[15:10]);
            r_offx <= OW'(ioff_x);
            r_offy <= OW'(ioff_y);
            r_px   <= QW'(ip_x);
            r_py   <= QW'(ip_y);
        end
        if (i_cmd.step) begin
            r_mx   <= n_mx;
            r_my   <= n_my;
            r_side <= !x_first;
            if (x_first) begin
                r_last <= r_offx;
                r_offx <= r_offx + OW'(grcd_pkg::ONE_Q10);
                r_px   <= r_px + QW'({r_ary, 10'd0});
            end else begin
                r_last <= r_offy;
                r_offy <= r_offy + OW'(grcd_pkg::ONE_Q10);
                r_py   <= r_py + QW'({r_arx, 10'd0});
            end
        end
        if (i_cmd.check) begin
            r_special <= (rdata == grcd_pkg::CODE_SPECIAL);
        end
    end

    // Result and output registers.
    logic [DW-1:0]              r_res_dist, r_out_dist;
    logic [grcd_pkg::SIDE_W-1:0] r_res_side, r_out_side;
    logic [CW-1:0]              r_res_x, r_res_y, r_out_x, r_out_y;
    logic                       r_res_nohit, r_out_nohit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_nohit) begin
            r_res_dist  <= grcd_pkg::DIST_MAX;
            r_res_side  <= grcd_pkg::SIDE_X;
            r_res_x     <= '0;
            r_res_y     <= '0;
            r_res_nohit <= 1'b1;
        end else if (i_cmd.ld_dist) begin
            r_res_dist  <= (quot > NW'(grcd_pkg::DIST_MAX)) ? grcd_pkg::DIST_MAX : DW'(quot);
            r_res_side  <= r_special ? grcd_pkg::SIDE_SPECIAL
                                     : (r_side ? grcd_pkg::SIDE_Y : grcd_pkg::SIDE_X);
            r_res_x     <= CW'(r_mx[MW-2:0]);
            r_res_y     <= CW'(r_my[MW-2:0]);
            r_res_nohit <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out_dist  <= r_res_dist;
            r_out_side  <= r_res_side;
            r_out_x     <= r_res_x;
            r_out_y     <= r_res_y;
            r_out_nohit <= r_res_nohit;
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.init_miss = ((r_arx == '0) && (r_ary == '0))
                             || (32'(r_pos_x[15:10]) >= MAP_DIM)
                             || (32'(r_pos_y[15:10]) >= MAP_DIM);
    assign o_sts.step_out  = !n_in;
    assign o_sts.cell_hit  = (rdata != grcd_pkg::CODE_EMPTY);

    assign o_distance = r_out_dist;
    assign o_hit_side = r_out_side;
    assign o_hit_x    = r_out_x;
    assign o_hit_y    = r_out_y;
    assign o_no_hit   = r_out_nohit;

endmodule

// ----- src/grid_ray_cast_dda_top.sv -----
// Grid ray caster over a stored tile map, walking cell boundaries by DDA.
// Input stream: each beat carries one item. tuser[0] = 0 writes cell_code into
// the map at (cell_x, cell_y) and gives no result; tuser[0] = 1 casts the ray
// for a screen column and gives exactly one result beat.
// Output stream: distance (Q10.10, saturated), hit side, hit cell, and in
// tuser[0] a flag set when no wall was found within MAX_STEPS crossings or
// inside the map.
// A write is taken while the control stays idle, so writes can follow back to
// back. A cast forms the ray (camera coordinate, products, ray, walk start),
// then walks crossing by crossing (pick the nearer boundary and address the
// map, then the registered map read), and for a hit starts the serial divider
// and loads the distance once it finishes.
// Items are taken one at a time; the next one is accepted as soon as the result
// moves to the output register, and it may wait there for the receiver.
// When the receiver stalls with a result still held, the next cast finishes
// and waits before loading its result, and the input stays not ready meanwhile.
// Reset clears control state and restores the camera registers; the map is kept.
// The user writes configuration only while no item is active; it is unchecked.
module grid_ray_cast_dda_top #(
    parameter int MAP_DIM   = grcd_pkg::MAP_DIM_DEF,
    parameter int SCREEN_W  = grcd_pkg::SCREEN_W_DEF,
    parameter int MAX_STEPS = grcd_pkg::MAX_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [grcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grcd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cell_x[5:0], cell_y[11:6], cell_code[19:12], column[29:20], zero[31:30]
    input  logic [31:0]                    s_axis_tdata,
    // opcode[0]
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // distance[19:0], hit_side[21:20], hit_x[27:22], hit_y[33:28], zero[39:34]
    output logic [39:0]                    m_axis_tdata,
    // no_hit[0]
    output logic [0:0]                     m_axis_tuser
);

    grcd_pkg::t_cmd cmd;
    grcd_pkg::t_sts sts;

    logic [grcd_pkg::DIST_W-1:0]  distance;
    logic [grcd_pkg::SIDE_W-1:0]  hit_side;
    logic [grcd_pkg::COORD_W-1:0] hit_x, hit_y;
    logic                         no_hit;

    grcd_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_op    (s_axis_tuser[0]),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    grcd_dp #(.MAP_DIM(MAP_DIM), .SCREEN_W(SCREEN_W)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cell_x    (s_axis_tdata[5:0]),
        .i_cell_y    (s_axis_tdata[11:6]),
        .i_cell_code (s_axis_tdata[19:12]),
        .i_column    (s_axis_tdata[29:20]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_distance  (distance),
        .o_hit_side  (hit_side),
        .o_hit_x     (hit_x),
        .o_hit_y     (hit_y),
        .o_no_hit    (no_hit)
    );

    assign m_axis_tdata = {6'd0, hit_y, hit_x, hit_side, distance};
    assign m_axis_tuser = no_hit;

endmodule

// ----- verif/grid_ray_cast_dda_top_test.sv -----
module grid_ray_cast_dda_top_test;

    typedef struct packed {
        logic [grcd_pkg::DIST_W-1:0]  distance;
        logic [grcd_pkg::SIDE_W-1:0]  hit_side;
        logic [grcd_pkg::COORD_W-1:0] hit_x;
        logic [grcd_pkg::COORD_W-1:0] hit_y;
        logic                         no_hit;
    } t_hit;

    typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_CAST, ROW_CAST_TYPED} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [2:0]         reg_idx;
        logic [15:0]        reg_val;
        logic [5:0]         cx;
        logic [5:0]         cy;
        logic [7:0]         code;
        logic [9:0]         col;
        t_hit               typed;
    } t_row;

    localparam int WALK_LIMIT = grcd_pkg::MAX_STEPS_DEF;
    localparam int MAP_LAST = grcd_pkg::MAP_DIM_DEF - 1;
    // The viewer stays in a walled room in the low corner of the map: cells below
    // ROOM on both axes, with walls on column x = ROOM and row y = ROOM. A ray
    // either hits a wall or leaves the map at the low edges, so it only reads
    // cells that have been written.
    localparam int ROOM = 8;
    localparam int POS_SPAN = ROOM * 1024 - 1;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_ITEMS = 106;
    localparam t_hit MISS = '{grcd_pkg::DIST_MAX, grcd_pkg::SIDE_X, 6'd0, 6'd0, 1'b1};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    grid_ray_cast_dda_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Mirror of the camera registers and the tile map.
    logic [15:0] pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
    logic [7:0]  map_img [64][64];

    t_hit pending_hits [$];
    int   errors;
    bit   idle_on;
    int   rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 6000000);
        $display("FAIL grid_ray_cast_dda_top");
        $finish;
    end

    function automatic longint abs_of(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_hit trace_ray(input logic [9:0] col);
        longint cam, rx, ry, arx, ary, mx, my, sx, sy, offx, offy, last, d;
        logic [1:0] side;
        logic [7:0] code;
        t_hit r;
        r = MISS;
        cam = longint'(col) * 32 - 16384;
        rx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> 14);
        ry = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> 14);
        arx = abs_of(rx);
        ary = abs_of(ry);
        mx = longint'(pos_x >> 10);
        my = longint'(pos_y >> 10);
        if (arx == 0 && ary == 0) return r;
        sx = rx < 0 ? -1 : 1;
        offx = rx < 0 ? longint'(pos_x[9:0]) : 1024 - longint'(pos_x[9:0]);
        sy = ry < 0 ? -1 : 1;
        offy = ry < 0 ? longint'(pos_y[9:0]) : 1024 - longint'(pos_y[9:0]);
        for (int i = 0; i < WALK_LIMIT; i++) begin
            if (offx * ary < offy * arx) begin
                mx += sx; side = grcd_pkg::SIDE_X; last = offx; offx += 1024;
            end else begin
                my += sy; side = grcd_pkg::SIDE_Y; last = offy; offy += 1024;
            end
            if (mx < 0 || mx > MAP_LAST || my < 0 || my > MAP_LAST) return r;
            code = map_img[mx][my];
            if (code != grcd_pkg::CODE_EMPTY) begin
                d = (last * 16384) / (side == grcd_pkg::SIDE_X ? arx : ary);
                r.distance = d > longint'(grcd_pkg::DIST_MAX) ? grcd_pkg::DIST_MAX
                                                              : d[grcd_pkg::DIST_W-1:0];
                r.hit_side = code == grcd_pkg::CODE_SPECIAL ? grcd_pkg::SIDE_SPECIAL : side;
                r.hit_x = mx[5:0];
                r.hit_y = my[5:0];
                r.no_hit = 1'b0;
                return r;
            end
        end
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            grcd_pkg::CFG_POS_X:   pos_x = val;
            grcd_pkg::CFG_POS_Y:   pos_y = val;
            grcd_pkg::CFG_DIR_X:   dir_x = val;
            grcd_pkg::CFG_DIR_Y:   dir_y = val;
            grcd_pkg::CFG_PLANE_X: plane_x = val;
            grcd_pkg::CFG_PLANE_Y: plane_y = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Called at a clock edge; returns at the edge where the beat was taken.
    task automatic send_item(input logic op, input logic [5:0] cx, input logic [5:0] cy,
                             input logic [7:0] code, input logic [9:0] col,
                             input bit typed, input t_hit typed_hit);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, col, code, cy, cx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == grcd_pkg::OP_WRITE) map_img[cx][cy] = code;
        else pending_hits.push_back(typed ? typed_hit : trace_ray(col));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 9) < 7)
            send_item(grcd_pkg::OP_CAST, 6'($urandom), 6'($urandom), 8'($urandom),
                      10'($urandom), 0, MISS);
        else
            send_item(grcd_pkg::OP_WRITE, 6'($urandom_range(0, ROOM - 1)),
                      6'($urandom_range(0, ROOM - 1)),
                      $urandom_range(0, 3) == 0 ? 8'($urandom) : grcd_pkg::CODE_EMPTY,
                      10'($urandom), 0, MISS);
    endtask

    // Receiver: checks each result beat and stalls in bursts.
    initial begin
        t_hit want, got;
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[19:0], m_axis_tdata[21:20], m_axis_tdata[27:22],
                        m_axis_tdata[33:28], m_axis_tuser[0]};
                if (pending_hits.size() == 0) begin
                    $display("%0t: result beat expected none actual %h", $realtime, got);
                    errors++;
                end else begin
                    want = pending_hits.pop_front();
                    if (got.distance !== want.distance) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $realtime, want.distance, got.distance);
                        errors++;
                    end
                    if (got.hit_side !== want.hit_side) begin
                        $display("%0t: hit_side expected %0d actual %0d",
                                 $realtime, want.hit_side, got.hit_side);
                        errors++;
                    end
                    if (got.hit_x !== want.hit_x || got.hit_y !== want.hit_y) begin
                        $display("%0t: hit cell expected (%0d,%0d) actual (%0d,%0d)", $realtime,
                                 want.hit_x, want.hit_y, got.hit_x, got.hit_y);
                        errors++;
                    end
                    if (got.no_hit !== want.no_hit) begin
                        $display("%0t: no_hit expected %0b actual %0b",
                                 $realtime, want.no_hit, got.no_hit);
                        errors++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row r;
        logic [7:0] fill;
        errors = 0;
        idle_on = 0;
        rx_hold = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        pos_x = grcd_pkg::RST_POS_X; pos_y = grcd_pkg::RST_POS_Y;
        dir_x = grcd_pkg::RST_DIR_X; dir_y = grcd_pkg::RST_DIR_Y;
        plane_x = grcd_pkg::RST_PLANE_X; plane_y = grcd_pkg::RST_PLANE_Y;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The room and its walls are written before any ray can reach them.
        for (int x = 0; x <= ROOM; x++)
            for (int y = 0; y <= ROOM; y++) begin
                if (x == ROOM || y == ROOM)
                    fill = $urandom_range(0, 3) == 0 ? grcd_pkg::CODE_SPECIAL
                                                     : 8'($urandom_range(1, 255));
                else if ($urandom_range(0, 7) == 0)
                    fill = $urandom_range(0, 2) == 0 ? grcd_pkg::CODE_SPECIAL
                                                     : 8'($urandom_range(1, 255));
                else
                    fill = grcd_pkg::CODE_EMPTY;
                send_item(grcd_pkg::OP_WRITE, 6'(x), 6'(y), fill, 10'($urandom), 0, MISS);
            end
        idle_on = 1;

        rows = '{
            '{ROW_CAST, '0, '0, '0, '0, '0, 10'd0, MISS},
            '{ROW_CAST, '0, '0, '0, '0, '0, 10'd1023, MISS},
            '{ROW_CAST, '0, '0, '0, '0, '0, 10'd512, MISS},
            // A ray pointing at negative x from the origin leaves the map at once.
            '{ROW_CFG, grcd_pkg::CFG_DIR_X, 16'hC000, '0, '0, '0, '0, MISS},
            '{ROW_CFG, grcd_pkg::CFG_PLANE_Y, 16'h0000, '0, '0, '0, '0, MISS},
            '{ROW_CAST_TYPED, '0, '0, '0, '0, '0, 10'd300, MISS},
            // Zero ray.
            '{ROW_CFG, grcd_pkg::CFG_DIR_X, 16'h0000, '0, '0, '0, '0, MISS},
            '{ROW_CAST_TYPED, '0, '0, '0, '0, '0, 10'd700, MISS},
            '{ROW_CFG, grcd_pkg::CFG_POS_X, 16'h1200, '0, '0, '0, '0, MISS},
            '{ROW_CFG, grcd_pkg::CFG_POS_Y, 16'h1064, '0, '0, '0, '0, MISS},
            '{ROW_WRITE, '0, '0, 6'd5, 6'd4, grcd_pkg::CODE_SPECIAL, '0, MISS},
            '{ROW_WRITE, '0, '0, 6'd3, 6'd4, 8'd255, '0, MISS},
            '{ROW_WRITE, '0, '0, 6'd4, 6'd5, 8'd1, '0, MISS},
            '{ROW_WRITE, '0, '0, 6'd4, 6'd3, grcd_pkg::CODE_SPECIAL, '0, MISS},
            '{ROW_CFG, grcd_pkg::CFG_DIR_X, 16'h4000, '0, '0, '0, '0, MISS},
            '{ROW_CAST_TYPED, '0, '0, '0, '0, '0, 10'd5,
              '{20'd512, grcd_pkg::SIDE_SPECIAL, 6'd5, 6'd4, 1'b0}},
            '{ROW_CFG, grcd_pkg::CFG_DIR_X, 16'hC000, '0, '0, '0, '0, MISS},
            '{ROW_CAST_TYPED, '0, '0, '0, '0, '0, 10'd1000,
              '{20'd512, grcd_pkg::SIDE_X, 6'd3, 6'd4, 1'b0}},
            // The smallest ray component saturates the distance.
            '{ROW_CFG, grcd_pkg::CFG_DIR_X, 16'h0001, '0, '0, '0, '0, MISS},
            '{ROW_CAST_TYPED, '0, '0, '0, '0, '0, 10'd99,
              '{grcd_pkg::DIST_MAX, grcd_pkg::SIDE_SPECIAL, 6'd5, 6'd4, 1'b0}},
            '{ROW_CFG, grcd_pkg::CFG_DIR_X, 16'h4000, '0, '0, '0, '0, MISS},
            '{ROW_CFG, grcd_pkg::CFG_DIR_Y, 16'h8000, '0, '0, '0, '0, MISS},
            '{ROW_CFG, grcd_pkg::CFG_PLANE_X, 16'h7FFF, '0, '0, '0, '0, MISS},
            '{ROW_CFG, grcd_pkg::CFG_PLANE_Y, 16'h8000, '0, '0, '0, '0, MISS},
            '{ROW_CAST, '0, '0, '0, '0, '0, 10'd0, MISS},
            '{ROW_CAST, '0, '0, '0, '0, '0, 10'd1023, MISS},
            '{ROW_CAST, '0, '0, '0, '0, '0, 10'd777, MISS}
        };
        foreach (rows[i]) begin
            r = rows[i];
            case (r.kind)
                ROW_CFG: begin
                    drain();
                    write_reg(r.reg_idx, r.reg_val);
                end
                ROW_WRITE: send_item(grcd_pkg::OP_WRITE, r.cx, r.cy, r.code, r.col, 0, MISS);
                ROW_CAST:  send_item(grcd_pkg::OP_CAST, r.cx, r.cy, r.code, r.col, 0, MISS);
                default:   send_item(grcd_pkg::OP_CAST, r.cx, r.cy, r.code, r.col, 1, r.typed);
            endcase
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            if (ph == 7) idle_on = 0;
            if (ph == 0) begin
                write_reg(grcd_pkg::CFG_POS_X, 16'h0000);
                write_reg(grcd_pkg::CFG_POS_Y, 16'(POS_SPAN));
                write_reg(grcd_pkg::CFG_DIR_X, 16'h7FFF);
                write_reg(grcd_pkg::CFG_DIR_Y, 16'h7FFF);
                write_reg(grcd_pkg::CFG_PLANE_X, 16'h8000);
                write_reg(grcd_pkg::CFG_PLANE_Y, 16'h7FFF);
            end else if (ph == 1) begin
                write_reg(grcd_pkg::CFG_POS_X, 16'(POS_SPAN));
                write_reg(grcd_pkg::CFG_POS_Y, 16'h0000);
                write_reg(grcd_pkg::CFG_DIR_X, 16'h8000);
                write_reg(grcd_pkg::CFG_DIR_Y, 16'h0001);
                write_reg(grcd_pkg::CFG_PLANE_X, 16'h0000);
                write_reg(grcd_pkg::CFG_PLANE_Y, 16'h8000);
            end else begin
                write_reg(grcd_pkg::CFG_POS_X, 16'($urandom_range(0, POS_SPAN)));
                write_reg(grcd_pkg::CFG_POS_Y, 16'($urandom_range(0, POS_SPAN)));
                write_reg(grcd_pkg::CFG_DIR_X, 16'($urandom));
                write_reg(grcd_pkg::CFG_DIR_Y, 16'($urandom));
                write_reg(grcd_pkg::CFG_PLANE_X, 16'($urandom));
                write_reg(grcd_pkg::CFG_PLANE_Y, 16'($urandom));
            end
            // Long receiver stall while casts keep coming, so the input backs up.
            if (ph == 3) rx_hold = 3000;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 60) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_hits.size() != 0) @(posedge i_clk);
                end
                random_item();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("PASS grid_ray_cast_dda_top");
        end else begin
            $display("FAIL grid_ray_cast_dda_top");
        end
        $finish;
    end
endmodule

// ----- grid_ray_cast_dda_top.f -----
src/grcd_pkg.sv
src/grcd_ram.sv
src/grcd_div.sv
src/grcd_ctrl.sv
src/grcd_dp.sv
src/grid_ray_cast_dda_top.sv
verif/grid_ray_cast_dda_top_test.sv
